// ===== hdl/rbd_pkg.sv =====
// Package for the ring buffer deque: sizes, codes, state and control types.
// No dependencies; used by every other file of the block but rbd_ram.
`timescale 1ns / 1ps

package rbd_pkg;

    // storage geometry
    localparam int DEPTH  = 1024;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // port field widths
    localparam int ACTION_W = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [DATA_W-1:0] t_data;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE       = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_PUSH_BACK  = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_POP_BACK   = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic fetch;
        logic publish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_fetch;
        logic out_busy;
    } t_dp_status;

    function automatic t_addr slot_next(input t_addr i);
        slot_next = (i == t_addr'(DEPTH - 1)) ? '0 : t_addr'(i + 1'b1);
    endfunction

    function automatic t_addr slot_prev(input t_addr i);
        slot_prev = (i == '0) ? t_addr'(DEPTH - 1) : t_addr'(i - 1'b1);
    endfunction

endpackage

// ===== hdl/rbd_if.sv =====
// Valid/ready channel interfaces for the deque's operation and result words.
// Depends on rbd_pkg for field widths.
`timescale 1ns / 1ps

interface rbd_in_if;
    logic                          valid;
    logic                          ready;
    logic [rbd_pkg::ACTION_W-1:0]  action;
    logic [rbd_pkg::WORD_W-1:0]    value;

    modport source (output valid, action, value, input ready);
    modport sink   (input valid, action, value, output ready);
endinterface

interface rbd_out_if;
    logic                          valid;
    logic                          ready;
    logic [rbd_pkg::WORD_W-1:0]    popped_item;
    logic [rbd_pkg::STATUS_W-1:0]  status;
    logic [rbd_pkg::COUNT_W-1:0]   entry_count;
    logic                          is_empty;
    logic [rbd_pkg::WORD_W-1:0]    front_item;
    logic [rbd_pkg::WORD_W-1:0]    back_item;

    modport source (output valid, popped_item, status, entry_count, is_empty,
                    front_item, back_item, input ready);
    modport sink   (input valid, popped_item, status, entry_count, is_empty,
                    front_item, back_item, output ready);
endinterface

// ===== hdl/rbd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/rbd_ctrl.sv =====
// Sequencer for the deque: accept, execute, optional RAM fetch, publish.
// Depends on rbd_pkg.
`timescale 1ns / 1ps

module rbd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  rbd_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output rbd_pkg::t_cmd       o_cmd
);

    rbd_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rbd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rbd_pkg::S_IDLE: begin
                if (i_in_valid) n_state = rbd_pkg::S_EXEC;
            end
            rbd_pkg::S_EXEC: begin
                n_state = i_status.need_fetch ? rbd_pkg::S_FETCH : rbd_pkg::S_DONE;
            end
            rbd_pkg::S_FETCH: begin
                n_state = rbd_pkg::S_DONE;
            end
            rbd_pkg::S_DONE: begin
                if (!i_status.out_busy) n_state = rbd_pkg::S_IDLE;
            end
            default: n_state = rbd_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        unique case (r_state)
            rbd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            rbd_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            rbd_pkg::S_FETCH: begin
                o_cmd.fetch = 1'b1;
            end
            rbd_pkg::S_DONE: begin
                o_cmd.publish = !i_status.out_busy;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/rbd_datapath.sv =====
// Deque datapath: pointers, count, cached front/back words, entry RAM and
// the result register. Depends on rbd_pkg and rbd_ram.
`timescale 1ns / 1ps

module rbd_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rbd_pkg::t_cmd                  i_cmd,
    input  logic [rbd_pkg::ACTION_W-1:0]   i_action,
    input  logic [rbd_pkg::WORD_W-1:0]     i_value,
    input  logic                           i_out_ready,
    output rbd_pkg::t_dp_status            o_status,
    output logic                           o_out_valid,
    output logic [rbd_pkg::WORD_W-1:0]     o_popped_item,
    output logic [rbd_pkg::STATUS_W-1:0]   o_result_status,
    output logic [rbd_pkg::COUNT_W-1:0]    o_entry_count,
    output logic                           o_is_empty,
    output logic [rbd_pkg::WORD_W-1:0]     o_front_item,
    output logic [rbd_pkg::WORD_W-1:0]     o_back_item
);

    // latched operation
    rbd_pkg::t_action r_act;
    rbd_pkg::t_data   r_val;

    // deque state
    rbd_pkg::t_addr   r_head, r_tail;
    rbd_pkg::t_count  r_count;
    rbd_pkg::t_data   r_front, r_back;

    // per-operation results
    rbd_pkg::t_data   r_popped;
    rbd_pkg::t_status r_stat;
    logic             r_fetch_back;

    // result register
    logic                          r_out_valid;
    logic [rbd_pkg::WORD_W-1:0]    r_out_popped, r_out_front, r_out_back;
    logic [rbd_pkg::STATUS_W-1:0]  r_out_status;
    logic [rbd_pkg::COUNT_W-1:0]   r_out_count;
    logic                          r_out_empty;

    logic           is_full, is_empty_now, last_one;
    logic           do_push_f, do_push_b, do_pop_f, do_pop_b;
    rbd_pkg::t_addr head_prev, head_next, tail_prev, tail_prev2;
    logic           ram_we;
    rbd_pkg::t_addr ram_waddr, ram_raddr;
    rbd_pkg::t_data ram_rdata;

    assign is_full      = (r_count == rbd_pkg::t_count'(rbd_pkg::DEPTH));
    assign is_empty_now = (r_count == '0);
    assign last_one     = (r_count == rbd_pkg::t_count'(1));

    assign head_prev  = rbd_pkg::slot_prev(r_head);
    assign head_next  = rbd_pkg::slot_next(r_head);
    assign tail_prev  = rbd_pkg::slot_prev(r_tail);
    assign tail_prev2 = rbd_pkg::slot_prev(tail_prev);

    assign do_push_f = (r_act == rbd_pkg::ACT_PUSH_FRONT) && !is_full;
    assign do_push_b = (r_act == rbd_pkg::ACT_PUSH_BACK)  && !is_full;
    assign do_pop_f  = (r_act == rbd_pkg::ACT_POP_FRONT)  && !is_empty_now;
    assign do_pop_b  = (r_act == rbd_pkg::ACT_POP_BACK)   && !is_empty_now;

    // a pop that leaves entries must reload the new end word from RAM
    assign o_status.need_fetch = (do_pop_f || do_pop_b) && !last_one;
    assign o_status.out_busy   = r_out_valid && !i_out_ready;

    assign ram_we    = i_cmd.exec && (do_push_f || do_push_b);
    assign ram_waddr = do_push_f ? head_prev : r_tail;
    assign ram_raddr = do_pop_f ? head_next : tail_prev2;

    rbd_ram #(
        .WIDTH (rbd_pkg::DATA_W),
        .DEPTH (rbd_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_val),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= rbd_pkg::t_action'(i_action);
            r_val <= rbd_pkg::t_data'(i_value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            if (do_push_f) begin
                r_head  <= head_prev;
                r_count <= rbd_pkg::t_count'(r_count + 1'b1);
            end else if (do_push_b) begin
                r_tail  <= rbd_pkg::slot_next(r_tail);
                r_count <= rbd_pkg::t_count'(r_count + 1'b1);
            end else if (do_pop_f) begin
                r_head  <= head_next;
                r_count <= rbd_pkg::t_count'(r_count - 1'b1);
            end else if (do_pop_b) begin
                r_tail  <= tail_prev;
                r_count <= rbd_pkg::t_count'(r_count - 1'b1);
            end
        end
    end

    // cached end words, status and popped word
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_popped     <= '0;
            r_stat       <= rbd_pkg::ST_OK;
            r_fetch_back <= (r_act == rbd_pkg::ACT_POP_BACK);
            unique case (r_act)
                rbd_pkg::ACT_PUSH_FRONT: begin
                    if (is_full) begin
                        r_stat <= rbd_pkg::ST_PUSH_FULL;
                    end else begin
                        r_front <= r_val;
                        if (is_empty_now) r_back <= r_val;
                    end
                end
                rbd_pkg::ACT_PUSH_BACK: begin
                    if (is_full) begin
                        r_stat <= rbd_pkg::ST_PUSH_FULL;
                    end else begin
                        r_back <= r_val;
                        if (is_empty_now) r_front <= r_val;
                    end
                end
                rbd_pkg::ACT_POP_FRONT, rbd_pkg::ACT_POP_BACK: begin
                    if (is_empty_now) begin
                        r_stat <= rbd_pkg::ST_POP_EMPTY;
                    end else begin
                        r_popped <= (r_act == rbd_pkg::ACT_POP_FRONT) ? r_front : r_back;
                        if (last_one) begin
                            r_front <= '0;
                            r_back  <= '0;
                        end
                    end
                end
                default: begin
                    r_stat <= rbd_pkg::ST_OK;
                end
            endcase
        end else if (i_cmd.fetch) begin
            if (r_fetch_back) begin
                r_back <= ram_rdata;
            end else begin
                r_front <= ram_rdata;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // end words read as zero while empty (cached words are unset after reset)
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_popped <= rbd_pkg::WORD_W'(r_popped);
            r_out_status <= r_stat;
            r_out_count  <= rbd_pkg::COUNT_W'(r_count);
            r_out_empty  <= is_empty_now;
            r_out_front  <= is_empty_now ? '0 : rbd_pkg::WORD_W'(r_front);
            r_out_back   <= is_empty_now ? '0 : rbd_pkg::WORD_W'(r_back);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_popped_item   = r_out_popped;
    assign o_result_status = r_out_status;
    assign o_entry_count   = r_out_count;
    assign o_is_empty      = r_out_empty;
    assign o_front_item    = r_out_front;
    assign o_back_item     = r_out_back;

endmodule

// ===== hdl/ring_buffer_deque.sv =====
// Top level of the ring buffer deque: controller, datapath and assertions.
// Depends on rbd_pkg, rbd_if, rbd_ctrl and rbd_datapath.
`timescale 1ns / 1ps

// Channel   Dir  Word carried
// --------  ---  ----------------------------------------------------------
// i_cmd     in   action (3b), value (32b)
// o_res     out  popped_item, status, entry_count, is_empty, front_item,
//                back_item
//
// One operation at a time: accept, execute, publish.
// A pop that leaves entries behind adds a fetch step for the registered RAM
// read that refills the cached front or back word.
// Reset (sync, active low) clears pointers, count and handshake state; the
// entry RAM is not cleared and needs no clearing pass.
// A stalled result sits in the output register; the next word is still
// accepted and executed, and waits at publish until the register frees.

module ring_buffer_deque (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rbd_in_if.sink        i_cmd,
    rbd_out_if.source     o_res
);

    rbd_pkg::t_cmd       cmd;
    rbd_pkg::t_dp_status dp_status;

    rbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .i_status   (dp_status),
        .o_in_ready (i_cmd.ready),
        .o_cmd      (cmd)
    );

    rbd_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_action        (i_cmd.action),
        .i_value         (i_cmd.value),
        .i_out_ready     (o_res.ready),
        .o_status        (dp_status),
        .o_out_valid     (o_res.valid),
        .o_popped_item   (o_res.popped_item),
        .o_result_status (o_res.status),
        .o_entry_count   (o_res.entry_count),
        .o_is_empty      (o_res.is_empty),
        .o_front_item    (o_res.front_item),
        .o_back_item     (o_res.back_item)
    );

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------

    // sequencer strobes never overlap
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.exec, cmd.fetch, cmd.publish}))
        else $error("sequencer strobes overlap");

    // an accepted word is executed on the next cycle
    a_load_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> cmd.exec)
        else $error("accepted word not executed");

    // empty flag and count agree
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.is_empty == (o_res.entry_count == '0)))
        else $error("empty flag disagrees with count");

    // count stays within the store depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.entry_count <= rbd_pkg::COUNT_W'(rbd_pkg::DEPTH)))
        else $error("count beyond depth");

    // publish never overwrites a result that is still held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.publish |-> (!o_res.valid || o_res.ready))
        else $error("result overwritten");

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for ring_buffer_deque: a table of directed words, then
// random fill / drain / mixed phases, scored against typed rows or a deque predictor.
// Depends on rbd_pkg, rbd_if and the ring_buffer_deque RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_PERIOD  = 12;
    localparam int RST_CYCLES  = 10;
    localparam int IDLE_LIMIT  = 2000;  // cycles with no word moving on either side
    localparam int DRAIN_WAIT  = 16;    // settle time after the last due result, longer than a pop takes
    localparam int HOLD_AT     = 400;   // result count that triggers the long hold-off
    localparam int HOLD_CYCLES = 300;
    localparam int SHOW_MAX    = 10;
    localparam int SLOTS       = 8;     // in-flight bookkeeping, far above what can pile up

    // action codes the block treats as a plain query
    localparam logic [rbd_pkg::ACTION_W-1:0] ACT_SPARE_5 = 3'd5;
    localparam logic [rbd_pkg::ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [rbd_pkg::ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [rbd_pkg::WORD_W-1:0]  popped;
        rbd_pkg::t_status            status;
        logic [rbd_pkg::COUNT_W-1:0] count;
        logic                        empty;
        logic [rbd_pkg::WORD_W-1:0]  front;
        logic [rbd_pkg::WORD_W-1:0]  back;
    } t_result;

    typedef struct packed {
        logic [rbd_pkg::ACTION_W-1:0] act;
        logic [rbd_pkg::WORD_W-1:0]   val;
        logic                         typed;  // want holds a hand-written result
        t_result                      want;
    } t_row;

    typedef enum int {MIX_ANY, MIX_FILL, MIX_DRAIN} t_mix;

    localparam t_result NO_RES = '0;
    localparam int DIR_ROWS = 21;

    // Directed words. Typed rows are trivially known (reset, empty pops,
    // first pushes of the extremes, pop to empty); the rest use the predictor.
    localparam t_row DIRECTED [DIR_ROWS] = '{
        '{rbd_pkg::ACT_NONE,       32'h0000_0000, 1'b1,
          '{32'h0, rbd_pkg::ST_OK,        11'd0, 1'b1, 32'h0, 32'h0}},
        '{rbd_pkg::ACT_POP_FRONT,  32'h0000_0000, 1'b1,
          '{32'h0, rbd_pkg::ST_POP_EMPTY, 11'd0, 1'b1, 32'h0, 32'h0}},
        '{rbd_pkg::ACT_POP_BACK,   32'h0000_0000, 1'b1,
          '{32'h0, rbd_pkg::ST_POP_EMPTY, 11'd0, 1'b1, 32'h0, 32'h0}},
        '{rbd_pkg::ACT_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1,
          '{32'h0, rbd_pkg::ST_OK, 11'd1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
        '{rbd_pkg::ACT_PUSH_BACK,  32'h0000_0000, 1'b1,
          '{32'h0, rbd_pkg::ST_OK, 11'd2, 1'b0, 32'hFFFF_FFFF, 32'h0}},
        '{rbd_pkg::ACT_PUSH_FRONT, 32'h0000_0001, 1'b0, NO_RES},
        '{rbd_pkg::ACT_PUSH_BACK,  32'h8000_0000, 1'b0, NO_RES},
        '{rbd_pkg::ACT_NONE,       32'hDEAD_BEEF, 1'b0, NO_RES},
        '{ACT_SPARE_5,             32'hAAAA_AAAA, 1'b0, NO_RES},
        '{ACT_SPARE_6,             32'h5555_5555, 1'b0, NO_RES},
        '{ACT_SPARE_7,             32'h1234_5678, 1'b0, NO_RES},
        '{rbd_pkg::ACT_POP_FRONT,  32'hFFFF_FFFF, 1'b0, NO_RES},
        '{rbd_pkg::ACT_POP_BACK,   32'h0000_0000, 1'b0, NO_RES},
        '{rbd_pkg::ACT_POP_BACK,   32'h0000_0000, 1'b0, NO_RES},
        '{rbd_pkg::ACT_POP_FRONT,  32'h0000_0000, 1'b1,
          '{32'hFFFF_FFFF, rbd_pkg::ST_OK, 11'd0, 1'b1, 32'h0, 32'h0}},
        '{rbd_pkg::ACT_POP_BACK,   32'h0000_0000, 1'b1,
          '{32'h0, rbd_pkg::ST_POP_EMPTY, 11'd0, 1'b1, 32'h0, 32'h0}},
        '{rbd_pkg::ACT_PUSH_BACK,  32'hA5A5_5A5A, 1'b0, NO_RES},
        '{rbd_pkg::ACT_POP_FRONT,  32'h0000_0000, 1'b0, NO_RES},
        '{rbd_pkg::ACT_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0, NO_RES},
        '{rbd_pkg::ACT_POP_BACK,   32'h0000_0000, 1'b0, NO_RES},
        '{rbd_pkg::ACT_NONE,       32'h0000_0000, 1'b0, NO_RES}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    rbd_in_if  cmd_ch ();
    rbd_out_if res_ch ();

    ring_buffer_deque i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // deque predictor state
    rbd_pkg::t_data store_m [rbd_pkg::DEPTH];
    int    head_m;   // slot of the front entry
    int    tail_m;   // slot one past the back entry
    int    fill_m;

    // rows in flight and expected result words, both kept as small rings
    t_row    sent_rows [SLOTS];
    int      sent_wr;
    int      sent_rd;
    t_result due_results [SLOTS];
    int      due_wr;
    int      due_rd;
    int      mismatches;
    int      results_seen;

    // Apply one operation to the predicted deque and return its result word.
    task automatic deque_step(input logic [rbd_pkg::ACTION_W-1:0] act,
                              input logic [rbd_pkg::WORD_W-1:0] val,
                              output t_result res);
        res = '0;
        res.status = rbd_pkg::ST_OK;
        case (act)
            rbd_pkg::ACT_PUSH_FRONT, rbd_pkg::ACT_PUSH_BACK: begin
                if (fill_m == rbd_pkg::DEPTH) begin
                    res.status = rbd_pkg::ST_PUSH_FULL;
                end else if (act == rbd_pkg::ACT_PUSH_FRONT) begin
                    head_m = (head_m + rbd_pkg::DEPTH - 1) % rbd_pkg::DEPTH;
                    store_m[head_m] = rbd_pkg::t_data'(val);
                    fill_m++;
                end else begin
                    store_m[tail_m] = rbd_pkg::t_data'(val);
                    tail_m = (tail_m + 1) % rbd_pkg::DEPTH;
                    fill_m++;
                end
            end
            rbd_pkg::ACT_POP_FRONT, rbd_pkg::ACT_POP_BACK: begin
                if (fill_m == 0) begin
                    res.status = rbd_pkg::ST_POP_EMPTY;
                end else if (act == rbd_pkg::ACT_POP_FRONT) begin
                    res.popped = rbd_pkg::WORD_W'(store_m[head_m]);
                    head_m = (head_m + 1) % rbd_pkg::DEPTH;
                    fill_m--;
                end else begin
                    tail_m = (tail_m + rbd_pkg::DEPTH - 1) % rbd_pkg::DEPTH;
                    res.popped = rbd_pkg::WORD_W'(store_m[tail_m]);
                    fill_m--;
                end
            end
            default: ;  // query and spare codes change nothing
        endcase
        res.count = rbd_pkg::COUNT_W'(fill_m);
        res.empty = (fill_m == 0);
        if (fill_m != 0) begin
            res.front = rbd_pkg::WORD_W'(store_m[head_m]);
            res.back  = rbd_pkg::WORD_W'(
                store_m[(tail_m + rbd_pkg::DEPTH - 1) % rbd_pkg::DEPTH]);
        end
    endtask

    // Scoreboard: predict on every accepted operation, check every result word.
    always @(posedge i_clk) begin
        t_row    row;
        t_result pred;
        t_result got;
        t_result want;
        if (i_rst_n === 1'b1) begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                row = sent_rows[sent_rd % SLOTS];
                sent_rd++;
                deque_step(cmd_ch.action, cmd_ch.value, pred);
                due_results[due_wr % SLOTS] = row.typed ? row.want : pred;
                due_wr++;
            end
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                got.popped = res_ch.popped_item;
                got.status = rbd_pkg::t_status'(res_ch.status);
                got.count  = res_ch.entry_count;
                got.empty  = res_ch.is_empty;
                got.front  = res_ch.front_item;
                got.back   = res_ch.back_item;
                if (due_wr == due_rd) begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display("%0t: result word with nothing due: %p", $realtime, got);
                end else begin
                    want = due_results[due_rd % SLOTS];
                    due_rd++;
                    if (got.popped !== want.popped || got.status !== want.status ||
                        got.count !== want.count || got.empty !== want.empty ||
                        got.front !== want.front || got.back !== want.back) begin
                        mismatches++;
                        if (mismatches <= SHOW_MAX) begin
                            $display("%0t: result %0d mismatch", $realtime, results_seen);
                            $display("  exp pop=%h st=%0d cnt=%0d emp=%b front=%h back=%h",
                                     want.popped, want.status, want.count, want.empty,
                                     want.front, want.back);
                            $display("  got pop=%h st=%0d cnt=%0d emp=%b front=%h back=%h",
                                     got.popped, got.status, got.count, got.empty,
                                     got.front, got.back);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: ends the run if no word moves for too long.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (((cmd_ch.valid && cmd_ch.ready) === 1'b1) ||
                ((res_ch.valid && res_ch.ready) === 1'b1))
                idle = 0;
            else
                idle++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: segments of always-ready, random and strided ready, plus
    // one long hold-off mid-fill so the block backs up and stalls its input.
    initial begin : result_sink
        int  seg;
        int  mode;
        int  stride;
        bit  held_off;
        res_ch.ready = 1'b0;
        held_off = 1'b0;
        stride = 0;
        @(posedge i_rst_n);
        forever begin
            seg  = $urandom_range(20, 150);
            mode = $urandom_range(0, 3);
            repeat (seg) begin
                @(negedge i_clk);
                if (!held_off && results_seen >= HOLD_AT) begin
                    held_off = 1'b1;
                    res_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                end
                stride++;
                case (mode)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= ($urandom_range(0, 9) < 7);
                    2: res_ch.ready <= ($urandom_range(0, 9) < 3);
                    default: res_ch.ready <= (stride % 3 == 0);
                endcase
            end
        end
    end

    // sender burst state
    int burst_left;

    // Offer one operation word and hold it until taken; called at a falling
    // edge, returns at a falling edge. Bursts end in a random gap, sometimes none.
    task automatic send_word(input t_row row);
        int gap;
        sent_rows[sent_wr % SLOTS] = row;
        sent_wr++;
        cmd_ch.valid  <= 1'b1;
        cmd_ch.action <= row.act;
        cmd_ch.value  <= row.val;
        do @(posedge i_clk); while (cmd_ch.ready !== 1'b1);
        @(negedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    function automatic logic [rbd_pkg::ACTION_W-1:0] pick_action(input t_mix mix);
        int r;
        r = $urandom_range(0, 99);
        if (mix == MIX_FILL && r < 96)
            return (r < 48) ? rbd_pkg::ACT_PUSH_FRONT : rbd_pkg::ACT_PUSH_BACK;
        if (mix == MIX_DRAIN && r < 90)
            return (r < 45) ? rbd_pkg::ACT_POP_FRONT : rbd_pkg::ACT_POP_BACK;
        return rbd_pkg::ACTION_W'($urandom_range(0, 7));
    endfunction

    function automatic t_row random_row(input t_mix mix);
        t_row row;
        int   r;
        row = '0;
        row.act = pick_action(mix);
        r = $urandom_range(0, 7);
        row.val = (r == 0) ? '0 : (r == 1) ? '1 : rbd_pkg::WORD_W'($urandom());
        return row;
    endfunction

    initial begin : stimulus
        i_rst_n       = 1'b0;
        cmd_ch.valid  = 1'b0;
        cmd_ch.action = rbd_pkg::ACT_NONE;
        cmd_ch.value  = '0;
        head_m        = 0;
        tail_m        = 0;
        fill_m        = 0;
        sent_wr       = 0;
        sent_rd       = 0;
        due_wr        = 0;
        due_rd        = 0;
        mismatches    = 0;
        results_seen  = 0;
        burst_left    = $urandom_range(1, 30);
        foreach (store_m[i]) store_m[i] = '0;

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_word(DIRECTED[i]);

        // mixed traffic near empty: lots of refused pops and spare codes
        repeat (30) send_word(random_row(MIX_ANY));
        // push-heavy until full, then keep knocking on a full deque
        while (fill_m < rbd_pkg::DEPTH) send_word(random_row(MIX_FILL));
        repeat (12) send_word(random_row(MIX_FILL));
        repeat (30) send_word(random_row(MIX_DRAIN));
        repeat (20) send_word(random_row(MIX_ANY));

        cmd_ch.valid <= 1'b0;
        while (due_wr != due_rd) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
